// ===== rtl/bqf_pkg.sv =====
// Shared types, constants and register codes of the multichannel biquad filter.
package bqf_pkg;

   localparam int SAMPLE_W         = 24;
   localparam int CHAN_W           = 3;
   localparam int COEF_W           = 32;
   localparam int FRAC_SHIFT       = 28;
   localparam int CSR_INDEX_W      = 3;
   localparam int DEFAULT_CHANNELS = 8;

   localparam int SAMPLE_MAX = 8388607;
   localparam int SAMPLE_MIN = -8388608;

   localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh1000_0000;
   localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   // Per-channel filter history, one memory word per channel.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] y2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] x1;
   } hist_type;

   localparam int HIST_W = $bits(hist_type);

endpackage

// ===== rtl/bqf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bqf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bqf_coef_regs.sv =====
// Coefficient register file written through the configuration channel.
module bqf_coef_regs
   import bqf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata,
   output coef_set_type           coefs
);

   coef_set_type coef_ff;
   coef_set_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_B0:  coef_in.b0 = csr_wdata;
            REG_B1:  coef_in.b1 = csr_wdata;
            REG_B2:  coef_in.b2 = csr_wdata;
            REG_A1:  coef_in.a1 = csr_wdata;
            REG_A2:  coef_in.a2 = csr_wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   // The reset set makes the filter a pass-through.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{b0: COEF_ONE, b1: COEF_ZERO, b2: COEF_ZERO,
                      a1: COEF_ZERO, a2: COEF_ZERO};
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign csr_ready = 1'b1;
   assign coefs     = coef_ff;

endmodule

// ===== rtl/bqf_datapath.sv =====
// Five-term multiply-accumulate with rounding and saturation to the sample format.
module bqf_datapath
   import bqf_pkg::*;
(
   input  logic signed [SAMPLE_W-1:0] x,
   input  hist_type                   hist,
   input  coef_set_type               coefs,
   output logic signed [SAMPLE_W-1:0] y
);

   localparam int PROD_W = COEF_W + SAMPLE_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int Q_W    = ACC_W - FRAC_SHIFT;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
   localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(SAMPLE_MAX);
   localparam logic signed [Q_W-1:0]   Q_MIN      = Q_W'(SAMPLE_MIN);

   logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [ACC_W-1:0]  acc_shr;
   logic signed [Q_W-1:0]    q;

   always_comb begin
      p_b0 = coefs.b0 * x;
      p_b1 = coefs.b1 * hist.x1;
      p_b2 = coefs.b2 * hist.x2;
      p_a1 = coefs.a1 * hist.y1;
      p_a2 = coefs.a2 * hist.y2;

      acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);

      // Adding one half and shifting arithmetically rounds half toward plus infinity.
      acc_rnd = acc + ROUND_HALF;
      acc_shr = acc_rnd >>> FRAC_SHIFT;
      q       = acc_shr[Q_W-1:0];

      priority if (q > Q_MAX) begin
         y = SAMPLE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         y = SAMPLE_W'(Q_MIN);
      end else begin
         y = q[SAMPLE_W-1:0];
      end
   end

endmodule

// ===== rtl/multichannel_biquad_filter.sv =====
// Top level of the multichannel direct form I biquad filter.
//
//  Channel   Direction  Payload                                     Handshake
//  req_      in         tdata: sample_in[23:0]; tuser: channel[2:0]  tvalid/tready
//  rsp_      out        tdata: sample_out[23:0]; tuser: channel_out  tvalid/tready
//  csr_      in         csr_index[2:0], csr_wdata[31:0]              csr_valid/csr_ready
//
// One sample is accepted every cycle unless a stalled result holds the pipeline. The
// accepting edge loads the input register and reads the channel history from the history
// RAM; from that first stage the five multiplies, the sum, rounding and saturation run
// into the result register, which presents the result.
// Back-to-back samples of one channel take the history just written from a bypass register.
// Reset is synchronous and clears the per-channel valid bits at once: no clearing pass.
// A stalled result holds the pipeline; the input is ready whenever the first stage is empty
// or moves on into the result register.
module multichannel_biquad_filter
   import bqf_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input transactions.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,  // sample_in[23:0]
   input  logic [CHAN_W-1:0]      req_tuser,  // channel[2:0]
   // Result transactions.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]    rsp_tdata,  // sample_out[23:0]
   output logic [CHAN_W-1:0]      rsp_tuser,  // channel_out[2:0]
   // Coefficient writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W  = ADDR_W + CHAN_W;

   coef_set_type coefs;

   bqf_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   // Pipeline control and payload.
   logic                       s1_vld_ff;
   logic                       s1_fwd_ff;
   logic                       s1_rdv_ff;
   logic signed [SAMPLE_W-1:0] s1_x_ff;
   logic [CHAN_W-1:0]          s1_ch_ff;
   hist_type                   hist_wr_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic [CHAN_W-1:0]          rsp_ch_ff;
   logic [CHANNELS-1:0]        vld_ff;
   logic [CHANNELS-1:0]        vld_in;

   logic                       req_fire;
   logic                       s1_adv;
   logic [EXT_W-1:0]           req_ch_ext;
   logic [EXT_W-1:0]           s1_ch_ext;
   logic [ADDR_W-1:0]          req_addr;
   logic [ADDR_W-1:0]          s1_addr;
   logic                       req_chv;
   logic                       s1_chv;
   logic                       req_fwd;
   logic                       req_rdv;
   logic                       ram_wr;
   logic [HIST_W-1:0]          ram_rdata;
   hist_type                   hist_cur;
   hist_type                   hist_new;
   logic signed [SAMPLE_W-1:0] y;

   assign req_ch_ext = {{ADDR_W{1'b0}}, req_tuser};
   assign s1_ch_ext  = {{ADDR_W{1'b0}}, s1_ch_ff};
   assign req_addr   = req_ch_ext[ADDR_W-1:0];
   assign s1_addr    = s1_ch_ext[ADDR_W-1:0];
   assign req_chv    = req_ch_ext < EXT_W'(CHANNELS);
   assign s1_chv     = s1_ch_ext < EXT_W'(CHANNELS);

   assign s1_adv     = s1_vld_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign ram_wr     = s1_adv && s1_chv;

   // A sample of the channel that is written back in this cycle would read stale RAM data.
   assign req_fwd = ram_wr && req_chv && (req_addr == s1_addr);
   assign req_rdv = req_chv ? vld_ff[req_addr] : 1'b0;

   bqf_ram #(
      .WIDTH (HIST_W),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s1_addr),
      .wr_data (hist_new),
      .rd_en   (req_fire && req_chv),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // A channel that was never written, or lies beyond the channel count, has zero history.
   always_comb begin
      priority if (s1_fwd_ff) begin
         hist_cur = hist_wr_ff;
      end else if (s1_rdv_ff) begin
         hist_cur = hist_type'(ram_rdata);
      end else begin
         hist_cur = '0;
      end
      hist_new = '{y2: hist_cur.y1, y1: y, x2: hist_cur.x1, x1: s1_x_ff};
   end

   bqf_datapath u_datapath (
      .x     (s1_x_ff),
      .hist  (hist_cur),
      .coefs (coefs),
      .y     (y)
   );

   always_comb begin
      vld_in = vld_ff;
      if (ram_wr) begin
         vld_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         vld_ff <= vld_in;
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff   <= req_tdata;
         s1_ch_ff  <= req_tuser;
         s1_fwd_ff <= req_fwd;
         s1_rdv_ff <= req_rdv;
      end
      if (ram_wr) begin
         hist_wr_ff <= hist_new;
      end
      if (s1_adv) begin
         rsp_data_ff <= y;
         rsp_ch_ff   <= s1_ch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ch_ff;

   // The bypass is only ever selected for a sample of a channel within the channel count.
   a_fwd_valid_channel: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_fwd_ff) |-> s1_chv)
      else $error("bypass selected for a channel without history");

   // Every sample leaving the first stage lands in the result register.
   a_adv_to_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_valid_ff && rsp_ch_ff == $past(s1_ch_ff)))
      else $error("first stage advanced without filling the result register");

   // A taken result with nothing behind it leaves the result register empty.
   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !s1_adv) |=> !rsp_valid_ff)
      else $error("result transaction repeated");

   // Reset leaves every channel without history.
   a_reset_clears_history: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("history valid bits not cleared by reset");

endmodule

// ===== dv/tb_multichannel_biquad_filter.sv =====
// Self-checking testbench for the multichannel biquad filter with a per-channel predictor.
module tb_multichannel_biquad_filter;
   import bqf_pkg::*;

   localparam int N_CHAN             = DEFAULT_CHANNELS;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int FIRST_UNUSED_INDEX = int'(REG_A2) + 1;
   localparam int PHASE_ITEMS        = 100;

   localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [8] = '{
      24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001,
      24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h123456
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   channel;
   } filtered_type;

   class biquad_scoreboard;
      logic signed [COEF_W-1:0]   coef_set [5];
      logic signed [SAMPLE_W-1:0] x_one [N_CHAN];
      logic signed [SAMPLE_W-1:0] x_two [N_CHAN];
      logic signed [SAMPLE_W-1:0] y_one [N_CHAN];
      logic signed [SAMPLE_W-1:0] y_two [N_CHAN];
      filtered_type               expected_q [$];
      int                         mismatches;

      function new();
         coef_set[REG_B0] = COEF_ONE;
         coef_set[REG_B1] = COEF_ZERO;
         coef_set[REG_B2] = COEF_ZERO;
         coef_set[REG_A1] = COEF_ZERO;
         coef_set[REG_A2] = COEF_ZERO;
         for (int i = 0; i < N_CHAN; i++) begin
            x_one[i] = '0;
            x_two[i] = '0;
            y_one[i] = '0;
            y_two[i] = '0;
         end
         mismatches = 0;
      endfunction

      // Writes to indexes past the last coefficient are dropped by the block.
      function void write_coef(logic [CSR_INDEX_W-1:0] index, logic [COEF_W-1:0] value);
         if (index <= REG_A2) begin
            coef_set[index] = value;
         end
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] data, logic [CHAN_W-1:0] ch);
         logic signed [SAMPLE_W-1:0] xs;
         longint       x1;
         longint       x2;
         longint       y1;
         longint       y2;
         longint       acc;
         longint       y;
         filtered_type want;
         xs = data;
         x1 = 0;
         x2 = 0;
         y1 = 0;
         y2 = 0;
         if (ch < N_CHAN) begin
            x1 = longint'(x_one[ch]);
            x2 = longint'(x_two[ch]);
            y1 = longint'(y_one[ch]);
            y2 = longint'(y_two[ch]);
         end
         acc = longint'(coef_set[REG_B0]) * longint'(xs)
             + longint'(coef_set[REG_B1]) * x1
             + longint'(coef_set[REG_B2]) * x2
             - longint'(coef_set[REG_A1]) * y1
             - longint'(coef_set[REG_A2]) * y2;
         // Round half toward plus infinity, then an arithmetic shift gives the floor.
         y = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
         if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
         end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
         end
         if (ch < N_CHAN) begin
            x_two[ch] = x_one[ch];
            x_one[ch] = xs;
            y_two[ch] = y_one[ch];
            y_one[ch] = y[SAMPLE_W-1:0];
         end
         want.sample  = y[SAMPLE_W-1:0];
         want.channel = ch;
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("ERROR: %s", msg);
      endtask

      task check_result(logic [SAMPLE_W-1:0] data, logic [CHAN_W-1:0] ch);
         filtered_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h on channel %0d", data, ch));
         end else begin
            want = expected_q.pop_front();
            if (data !== want.sample) begin
               report_mismatch($sformatf("sample_out %h, predicted %h (channel %0d)",
                                         data, want.sample, want.channel));
            end
            if (ch !== want.channel) begin
               report_mismatch($sformatf("channel_out %0d, predicted %0d",
                                         ch, want.channel));
            end
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;
   logic [CHAN_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic [CHAN_W-1:0]      rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COEF_W-1:0]      csr_wdata;

   biquad_scoreboard sb = new();
   int gap_pct   = 8;
   int stall_pct = 8;
   int idle_cycles = 0;

   multichannel_biquad_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_sample(logic [SAMPLE_W-1:0] data, logic [CHAN_W-1:0] ch);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= ch;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(data, ch);
      @(negedge clock);
   endtask

   // Holds the input off until every predicted result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_coef(index, value);
      @(negedge clock);
   endtask

   // Loads all five coefficients, then one write to an unused index that must be ignored.
   task automatic load_coefs(logic [COEF_W-1:0] c [5]);
      for (int s = 0; s < 5; s++) begin
         write_csr(CSR_INDEX_W'(s), c[s]);
      end
      write_csr(CSR_INDEX_W'(FIRST_UNUSED_INDEX + $urandom_range(2)), $urandom());
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COEF_W-1:0] pick_coef(int kind, int slot);
      logic [COEF_W-1:0] value;
      case (kind)
         0: begin
            // Moderate values keep most outputs off the rails.
            if (slot == int'(REG_A1)) begin
               value = COEF_W'(int'($urandom_range(1 << 30)) - (1 << 29));
            end else begin
               value = COEF_W'(int'($urandom_range(1 << 28)) - (1 << 27));
            end
         end
         1: value = $urandom();
         default: begin
            case ($urandom_range(4))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = COEF_ZERO;
               3: value = COEF_ONE;
               default: value = -COEF_ONE;
            endcase
         end
      endcase
      return value;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      logic [SAMPLE_W-1:0] value;
      case ($urandom_range(9))
         0: value = SAMPLE_W'(SAMPLE_MAX);
         1: value = SAMPLE_W'(SAMPLE_MIN);
         2, 3, 4: value = SAMPLE_W'(int'($urandom_range(8191)) - 4096);
         default: value = SAMPLE_W'($urandom());
      endcase
      return value;
   endfunction

   initial begin
      logic [COEF_W-1:0] c [5];
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Reset coefficients pass samples through unchanged.
      for (int i = 0; i < 8; i++) begin
         send_sample(CORNER_SAMPLES[i], CHAN_W'(i));
      end

      // A gain of one half lands exactly on rounding ties.
      drain_results();
      c = '{32'h0800_0000, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
      load_coefs(c);
      send_sample(24'd1, '0);
      send_sample(-24'sd1, '0);
      send_sample(24'd3, '0);
      send_sample(-24'sd3, '0);

      // Extreme coefficients drive the accumulator into saturation both ways.
      drain_results();
      c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      load_coefs(c);
      for (int i = 0; i < 6; i++) begin
         send_sample(i[1] ? SAMPLE_W'(SAMPLE_MIN) : SAMPLE_W'(SAMPLE_MAX),
                     i[0] ? CHAN_W'(7) : CHAN_W'(3));
      end

      for (int p = 0; p < 6; p++) begin
         drain_results();
         for (int s = 0; s < 5; s++) begin
            c[s] = pick_coef(p % 3, s);
         end
         load_coefs(c);
         gap_pct   = (p == 3) ? 0 : 8;
         stall_pct = (p == 3) ? 0 : 8;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(49) == 0) begin
               drain_results();
            end
            send_sample(rand_sample(), CHAN_W'($urandom_range(7)));
         end
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
